// File: rtl/core/abrf_pkg.sv
// Package for the banked register file: operation and mode codes, the
// physical cell layout and the functions that map a view and register to a cell.
// No dependencies.
package abrf_pkg;

    // Physical storage layout.
    localparam int NUM_PHYS  = 37;
    localparam int CELL_W    = $clog2(NUM_PHYS);
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 5;
    localparam int REG_W     = 4;
    localparam int PC_CELL   = 30;
    localparam int CPSR_CELL = 31;
    localparam int SPSR_BASE = 32;

    // Processor mode encodings.
    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

    // Access operations carried in each input item.
    typedef enum logic [2:0] {
        OP_RD_REG  = 3'd0,
        OP_WR_REG  = 3'd1,
        OP_RD_USR  = 3'd2,
        OP_WR_USR  = 3'd3,
        OP_RD_CPSR = 3'd4,
        OP_WR_CPSR = 3'd5,
        OP_RD_SPSR = 3'd6,
        OP_WR_SPSR = 3'd7
    } t_op;

    // Register bank view selected by the mode; SYS also covers unknown codes.
    typedef enum logic [2:0] {
        VIEW_USR = 3'd0,
        VIEW_FIQ = 3'd1,
        VIEW_IRQ = 3'd2,
        VIEW_SVC = 3'd3,
        VIEW_ABT = 3'd4,
        VIEW_UND = 3'd5,
        VIEW_SYS = 3'd6
    } t_view;

    // Decoded access handed from the decoder to the storage control.
    typedef struct packed {
        logic [CELL_W-1:0] addr;
        logic              wr;
        logic              rd;
        logic              err;
    } t_access;

    // Status of the mode after an access.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              has_spsr;
        logic              privileged;
    } t_status;

    function automatic t_view view_of(logic [MODE_W-1:0] m);
        t_view v;
        begin
            case (m)
                MODE_USR: v = VIEW_USR;
                MODE_FIQ: v = VIEW_FIQ;
                MODE_IRQ: v = VIEW_IRQ;
                MODE_SVC: v = VIEW_SVC;
                MODE_ABT: v = VIEW_ABT;
                MODE_UND: v = VIEW_UND;
                default:  v = VIEW_SYS;
            endcase
            return v;
        end
    endfunction

    function automatic logic view_has_spsr(t_view v);
        return (v != VIEW_USR) && (v != VIEW_SYS);
    endfunction

    // Physical cell of an architectural register seen through a view.
    function automatic logic [CELL_W-1:0] cell_of(t_view v, logic [REG_W-1:0] r);
        logic [CELL_W-1:0] r6;
        logic [CELL_W-1:0] c;
        begin
            r6 = CELL_W'(r);
            if (r == 4'd15) begin
                c = CELL_W'(PC_CELL);
            end else if (r <= 4'd7) begin
                c = r6;
            end else if (r <= 4'd12) begin
                c = (v == VIEW_FIQ) ? r6 + CELL_W'(5) : r6;
            end else begin
                case (v)
                    VIEW_FIQ: c = r6 + CELL_W'(7);
                    VIEW_IRQ: c = r6 + CELL_W'(9);
                    VIEW_SVC: c = r6 + CELL_W'(11);
                    VIEW_ABT: c = r6 + CELL_W'(13);
                    VIEW_UND: c = r6 + CELL_W'(15);
                    default:  c = r6 + CELL_W'(5);
                endcase
            end
            return c;
        end
    endfunction

    // SPSR cell of a view that owns one.
    function automatic logic [CELL_W-1:0] spsr_cell(t_view v);
        return CELL_W'(SPSR_BASE - 1) + CELL_W'(v);
    endfunction

endpackage

// File: rtl/core/arm_banked_register_file.sv
// Top level of the banked register file: input handshake, mode register,
// valid bits and the result stage. Depends on abrf_pkg, abrf_decode, abrf_ram.
// The result item of an accepted input item is registered and offered in the
// cycle after the accept. One item per cycle while results are taken; the single
// RAM read is registered, and the result stage is refilled on the cycle it is taken.
// Reset: the mode returns to SYS and all 37 valid bits clear, so every
// register reads as zero until written; there is no clearing pass.
module arm_banked_register_file (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // op[2:0], reg_index[6:3], write_value[38:7], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data[31:0], current_mode[36:32],
                                        // has_spsr[37], privileged[38], access_error[39]
);
    import abrf_pkg::*;

    t_op               in_op;
    logic [REG_W-1:0]  in_reg;
    logic [DATA_W-1:0] in_value;
    t_access           acc;
    t_status           stat;
    logic              accept;
    logic [DATA_W-1:0] ram_rdata;

    logic [MODE_W-1:0]   r_mode;
    logic [NUM_PHYS-1:0] r_cell_valid;
    logic                r_out_valid;
    logic                r_show_data;
    t_status             r_status;
    logic                r_err;

    // Unpack the input item.
    assign in_op    = t_op'(s_axis_tdata[2:0]);
    assign in_reg   = s_axis_tdata[6:3];
    assign in_value = s_axis_tdata[38:7];

    // A new item enters whenever the result stage is empty or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    abrf_decode u_decode (
        .i_op          (in_op),
        .i_reg_index   (in_reg),
        .i_write_value (in_value),
        .i_mode        (r_mode),
        .o_access      (acc),
        .o_status      (stat)
    );

    abrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_PHYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && acc.wr),
        .i_waddr (acc.addr),
        .i_wdata (in_value),
        .i_re    (accept && acc.rd),
        .i_raddr (acc.addr),
        .o_rdata (ram_rdata)
    );

    // Mode register, valid bits and result-stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SYS;
            r_cell_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_mode <= stat.mode;
                if (acc.wr) begin
                    r_cell_valid[acc.addr] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload captured with the item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_show_data <= acc.rd && r_cell_valid[acc.addr];
            r_status    <= stat;
            r_err       <= acc.err;
        end
    end

    // Pack the result item; unread or never-written cells show zero.
    assign m_axis_tvalid      = r_out_valid;
    assign m_axis_tdata[31:0] = r_show_data ? ram_rdata : '0;
    assign m_axis_tdata[36:32] = r_status.mode;
    assign m_axis_tdata[37]   = r_status.has_spsr;
    assign m_axis_tdata[38]   = r_status.privileged;
    assign m_axis_tdata[39]   = r_err;

endmodule

// File: rtl/core/abrf_ram.sv
// Generic simple dual-port RAM with separate write and read addresses and
// a registered read. No dependencies.
module abrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 37
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; holds its data while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/abrf_decode.sv
// Access decoder: turns an operation, register number and current mode into
// a physical cell access and the status after it. Depends on abrf_pkg.
module abrf_decode (
    input  abrf_pkg::t_op                   i_op,
    input  logic [abrf_pkg::REG_W-1:0]      i_reg_index,
    input  logic [abrf_pkg::DATA_W-1:0]     i_write_value,
    input  logic [abrf_pkg::MODE_W-1:0]     i_mode,
    output abrf_pkg::t_access               o_access,
    output abrf_pkg::t_status               o_status
);
    import abrf_pkg::*;

    t_view             cur_view;
    t_view             new_view;
    logic [MODE_W-1:0] new_mode;

    assign cur_view = view_of(i_mode);

    // Pick the cell and the kind of access for each operation.
    always_comb begin
        o_access.addr = cell_of(cur_view, i_reg_index);
        o_access.wr   = 1'b0;
        o_access.rd   = 1'b0;
        o_access.err  = 1'b0;
        new_mode      = i_mode;
        unique case (i_op)
            OP_RD_REG: begin
                o_access.rd = 1'b1;
            end
            OP_WR_REG: begin
                o_access.wr = 1'b1;
            end
            OP_RD_USR: begin
                o_access.addr = cell_of(VIEW_USR, i_reg_index);
                o_access.rd   = 1'b1;
            end
            OP_WR_USR: begin
                o_access.addr = cell_of(VIEW_USR, i_reg_index);
                o_access.wr   = 1'b1;
            end
            OP_RD_CPSR: begin
                o_access.addr = CELL_W'(CPSR_CELL);
                o_access.rd   = 1'b1;
            end
            OP_WR_CPSR: begin
                o_access.addr = CELL_W'(CPSR_CELL);
                o_access.wr   = 1'b1;
                new_mode      = i_write_value[MODE_W-1:0];
            end
            OP_RD_SPSR: begin
                o_access.addr = spsr_cell(cur_view);
                o_access.rd   = view_has_spsr(cur_view);
                o_access.err  = !view_has_spsr(cur_view);
            end
            default: begin
                o_access.addr = spsr_cell(cur_view);
                o_access.wr   = view_has_spsr(cur_view);
                o_access.err  = !view_has_spsr(cur_view);
            end
        endcase
    end

    // Status flags reflect the mode after the access.
    assign new_view            = view_of(new_mode);
    assign o_status.mode       = new_mode;
    assign o_status.has_spsr   = view_has_spsr(new_view);
    assign o_status.privileged = (new_view != VIEW_USR);

endmodule
